>>> design/lidar_front_sector_avoid_steer_macros.svh
// Assertion macros shared by the checker of the front sector steering block.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef LIDAR_FRONT_SECTOR_AVOID_STEER_MACROS_SVH
`define LIDAR_FRONT_SECTOR_AVOID_STEER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LFSAS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LFSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lfsas_pkg.sv
// ----------------------------------------------------------------------------
// lfsas_pkg
// Types, widths and register codes of the lidar front sector steering block.
// ----------------------------------------------------------------------------
package lfsas_pkg;

  // Field widths.
  localparam int RANGE_W   = 16;  // Q4.12 metres
  localparam int LEN_REG_W = 11;
  localparam int HW_W      = 9;
  localparam int THR_W     = 16;
  localparam int TURN_W    = 14;  // signed Q.12 rad/s
  localparam int SUM_W     = 26;

  // Turn magnitude: quotient below 2^13, 12 fraction bits.
  localparam int QUO_W     = 13;
  localparam int RATE_FRAC = 12;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int Q_DEPTH         = 2;

  // Register reset values.
  localparam logic [LEN_REG_W-1:0] SCAN_LENGTH_RST = 11'd1024;
  localparam logic [HW_W-1:0]      HALF_WIDTH_RST  = 9'd128;
  localparam logic [THR_W-1:0]     THRESHOLD_RST   = 16'd246;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_SCAN_LENGTH = 2'd0;
  localparam logic [1:0] REG_HALF_WIDTH  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;

  typedef struct packed {
    logic [LEN_REG_W-1:0] scan_length;
    logic [HW_W-1:0]      half_width;
    logic [THR_W-1:0]     threshold;
  } lfsas_cfg_t;

  // One finished scan, handed from the front to the back.
  typedef struct packed {
    logic [RANGE_W-1:0] nearest;
    logic [THR_W-1:0]   thresh;
    logic               left_gt;
  } lfsas_entry_t;

endpackage

>>> design/lfsas_cfg.sv
// ----------------------------------------------------------------------------
// lfsas_cfg
// Configuration registers behind a simple APB slave.
// ----------------------------------------------------------------------------
module lfsas_cfg
  import lfsas_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output lfsas_cfg_t            cfg_o
);

  lfsas_cfg_t cfg_q, cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SCAN_LENGTH: cfg_d.scan_length = pwdata[LEN_REG_W-1:0];
        REG_HALF_WIDTH:  cfg_d.half_width  = pwdata[HW_W-1:0];
        REG_THRESHOLD:   cfg_d.threshold   = pwdata[THR_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SCAN_LENGTH: prdata = APB_DATA_W'(cfg_q.scan_length);
      REG_HALF_WIDTH:  prdata = APB_DATA_W'(cfg_q.half_width);
      REG_THRESHOLD:   prdata = APB_DATA_W'(cfg_q.threshold);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_length <= SCAN_LENGTH_RST;
      cfg_q.half_width  <= HALF_WIDTH_RST;
      cfg_q.threshold   <= THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> design/lfsas_front.sv
// ----------------------------------------------------------------------------
// lfsas_front
// Takes range samples, finds the front sector and keeps its minimum and the
// left and right sums. The last sample of a scan pushes one entry.
// ----------------------------------------------------------------------------
module lfsas_front
  import lfsas_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfsas_cfg_t         cfg_i,
  input  logic [RANGE_W-1:0] range_sample_i,
  input  logic               range_valid_i,
  output logic               range_stall_o,
  input  logic               q_full_i,
  output logic               push_o,
  output lfsas_entry_t       push_entry_o
);

  localparam int CNT_W = $clog2(MAX_SAMPLES);
  localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
  // One spare bit so that index plus half-width never wraps.
  localparam int AW    = ((LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W) + 1;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [RANGE_W-1:0] min_q, min_d, min_nxt;
  logic [SUM_W-1:0]   left_q, left_d, left_nxt;
  logic [SUM_W-1:0]   right_q, right_d, right_nxt;

  logic [AW-1:0] scan_w, max_w, hw_w, idx_w, len_w, center_w, lim_w, hw_eff;
  logic          in_sector, is_last, accept;

  always_comb begin
    scan_w   = AW'(cfg_i.scan_length);
    max_w    = AW'(MAX_SAMPLES);
    hw_w     = AW'(cfg_i.half_width);
    idx_w    = AW'(cnt_q);
    if (scan_w == '0) begin
      len_w = AW'(1);
    end else if (scan_w > max_w) begin
      len_w = max_w;
    end else begin
      len_w = scan_w;
    end
    center_w = len_w >> 1;
    lim_w    = (len_w - AW'(1)) >> 1;
    hw_eff   = (hw_w > lim_w) ? lim_w : hw_w;
  end

  assign in_sector = (idx_w + hw_eff >= center_w) && (idx_w <= center_w + hw_eff);
  // A counter at or past the end, after a shorter length was written, also ends the scan.
  assign is_last   = (idx_w + AW'(1) >= len_w);

  assign range_stall_o = is_last && q_full_i;
  assign accept        = range_valid_i && !range_stall_o;

  assign min_nxt   = (in_sector && (range_sample_i < min_q)) ? range_sample_i : min_q;
  assign left_nxt  = left_q + ((in_sector && (idx_w > center_w)) ?
                               SUM_W'(range_sample_i) : '0);
  assign right_nxt = right_q + ((in_sector && (idx_w < center_w)) ?
                                SUM_W'(range_sample_i) : '0);

  assign push_o               = accept && is_last;
  assign push_entry_o.nearest = min_nxt;
  assign push_entry_o.thresh  = cfg_i.threshold;
  assign push_entry_o.left_gt = (left_nxt > right_nxt);

  always_comb begin
    cnt_d   = cnt_q;
    min_d   = min_q;
    left_d  = left_q;
    right_d = right_q;
    if (accept) begin
      if (is_last) begin
        cnt_d   = '0;
        min_d   = '1;
        left_d  = '0;
        right_d = '0;
      end else begin
        cnt_d   = cnt_q + CNT_W'(1);
        min_d   = min_nxt;
        left_d  = left_nxt;
        right_d = right_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      min_q   <= '1;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      min_q   <= min_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

>>> design/lfsas_queue.sv
// ----------------------------------------------------------------------------
// lfsas_queue
// Short FIFO of finished scans between the front and the back.
// ----------------------------------------------------------------------------
module lfsas_queue
  import lfsas_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  lfsas_entry_t push_entry_i,
  input  logic         pop_i,
  output lfsas_entry_t head_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  lfsas_entry_t     mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> design/lfsas_back.sv
// ----------------------------------------------------------------------------
// lfsas_back
// Turns one finished scan into a steering result. The turn magnitude
// round(4096 * (0.3 + 0.7 * (T - m) / T)) is formed exactly as
// floor((4096 * (10T - 7m) + 5T) / (10T)) by a restoring divider.
// ----------------------------------------------------------------------------
module lfsas_back
  import lfsas_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_empty_i,
  input  lfsas_entry_t             head_i,
  output logic                     pop_o,
  output logic                     result_valid_o,
  input  logic                     result_stall_i,
  output logic                     obstacle_seen_o,
  output logic signed [TURN_W-1:0] turn_rate_o,
  output logic [RANGE_W-1:0]       nearest_range_o
);

  localparam int DEN_W  = THR_W + 4;       // holds 10T
  localparam int REM_W  = DEN_W + QUO_W;   // holds 10T shifted to the top quotient bit
  localparam int STEP_W = $clog2(QUO_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               valid_q, valid_d;

  logic [REM_W-1:0]   rem_q, rem_d, den_q, den_d;
  logic [QUO_W-1:0]   quo_q, quo_d;
  logic [RANGE_W-1:0] near_q, near_d;
  logic               obst_q, obst_d, left_gt_q, left_gt_d;

  logic               out_obst_q, out_obst_d;
  logic signed [TURN_W-1:0] out_rate_q, out_rate_d;
  logic [RANGE_W-1:0] out_near_q, out_near_d;

  logic [DEN_W-1:0]   t10, m7;
  logic [REM_W-1:0]   num_ld, den_ld;
  logic               ge, out_free;
  logic signed [TURN_W-1:0] mag;

  // Operand setup: 10T by shift and add, 7m by shift and subtract.
  always_comb begin
    t10    = (DEN_W'(head_i.thresh) << 3) + (DEN_W'(head_i.thresh) << 1);
    m7     = (DEN_W'(head_i.nearest) << 3) - DEN_W'(head_i.nearest);
    num_ld = (REM_W'(t10 - m7) << RATE_FRAC) + (REM_W'(head_i.thresh) << 2)
             + REM_W'(head_i.thresh);
    den_ld = REM_W'(t10) << (QUO_W - 1);
  end

  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign out_free = !valid_q || !result_stall_i;
  assign ge       = (rem_q >= den_q);
  assign mag      = TURN_W'(quo_q);

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    valid_d    = valid_q && result_stall_i;
    rem_d      = rem_q;
    den_d      = den_q;
    quo_d      = quo_q;
    near_d     = near_q;
    obst_d     = obst_q;
    left_gt_d  = left_gt_q;
    out_obst_d = out_obst_q;
    out_rate_d = out_rate_q;
    out_near_d = out_near_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          near_d    = head_i.nearest;
          left_gt_d = head_i.left_gt;
          obst_d    = (head_i.nearest < head_i.thresh);
          rem_d     = num_ld;
          den_d     = den_ld;
          quo_d     = '0;
          step_d    = STEP_W'(QUO_W - 1);
          // A clear scan, a zero threshold included, needs no division.
          state_d   = (head_i.nearest < head_i.thresh) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (ge) begin
          rem_d = rem_q - den_q;
        end
        quo_d = {quo_q[QUO_W-2:0], ge};
        den_d = den_q >> 1;
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          valid_d    = 1'b1;
          out_obst_d = obst_q;
          out_near_d = near_q;
          if (!obst_q) begin
            out_rate_d = '0;
          end else if (left_gt_q) begin
            out_rate_d = mag;
          end else begin
            out_rate_d = -mag;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    den_q      <= den_d;
    quo_q      <= quo_d;
    near_q     <= near_d;
    obst_q     <= obst_d;
    left_gt_q  <= left_gt_d;
    out_obst_q <= out_obst_d;
    out_rate_q <= out_rate_d;
    out_near_q <= out_near_d;
  end

  assign result_valid_o  = valid_q;
  assign obstacle_seen_o = out_obst_q;
  assign turn_rate_o     = out_rate_q;
  assign nearest_range_o = out_near_q;

endmodule

>>> design/lidar_front_sector_avoid_steer.sv
// ----------------------------------------------------------------------------
// lidar_front_sector_avoid_steer
// Front sector obstacle check and avoidance steering over a lidar scan.
//
//   channel  direction  handshake                        payload
//   range    in         range_valid_i / range_stall_o    range_sample_i
//   result   out        result_valid_o / result_stall_i  obstacle_seen_o,
//                                                        turn_rate_o,
//                                                        nearest_range_o
//   config   in         APB write, psel & penable        pwdata at paddr
//
// The front takes one range sample per cycle; it stalls only on the last
// sample of a scan while the two-entry scan queue is full.
// For each scan the back loads the operands, runs 13 divider steps and loads
// the output register; a clear scan skips the divider steps.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result holds in the output register; the back divides on, then waits to load.
// ----------------------------------------------------------------------------
module lidar_front_sector_avoid_steer
  import lfsas_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [RANGE_W-1:0]       range_sample_i,
  input  logic                     range_valid_i,
  output logic                     range_stall_o,
  output logic                     obstacle_seen_o,
  output logic signed [TURN_W-1:0] turn_rate_o,
  output logic [RANGE_W-1:0]       nearest_range_o,
  output logic                     result_valid_o,
  input  logic                     result_stall_i,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  lfsas_cfg_t   cfg;
  lfsas_entry_t push_entry, head;
  logic         push, pop, q_full, q_empty;

  lfsas_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfsas_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .range_sample_i (range_sample_i),
    .range_valid_i  (range_valid_i),
    .range_stall_o  (range_stall_o),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  lfsas_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .full_o       (q_full),
    .empty_o      (q_empty)
  );

  lfsas_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .head_i          (head),
    .pop_o           (pop),
    .result_valid_o  (result_valid_o),
    .result_stall_i  (result_stall_i),
    .obstacle_seen_o (obstacle_seen_o),
    .turn_rate_o     (turn_rate_o),
    .nearest_range_o (nearest_range_o)
  );

endmodule

>>> design/lfsas_checker.sv
// ----------------------------------------------------------------------------
// lfsas_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_front_sector_avoid_steer_macros.svh"

module lfsas_checker
  import lfsas_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     result_valid_o,
  input logic                     result_stall_i,
  input logic                     obstacle_seen_o,
  input logic signed [TURN_W-1:0] turn_rate_o,
  input logic [RANGE_W-1:0]       nearest_range_o
);

  // A stalled result item keeps its valid and payload.
  `LFSAS_ASSERT_NEXT(a_result_hold, result_valid_o && result_stall_i, result_valid_o && $stable(obstacle_seen_o) && $stable(turn_rate_o) && $stable(nearest_range_o), "result changed while stalled")

  // A clear scan never steers.
  `LFSAS_ASSERT_SAME(a_clear_no_turn, result_valid_o && !obstacle_seen_o, turn_rate_o == '0, "clear result with nonzero turn rate")

  // An obstacle always steers, by at most one rad/s either way.
  `LFSAS_ASSERT_SAME(a_obst_turn_range, result_valid_o && obstacle_seen_o, (turn_rate_o != '0) && (turn_rate_o <= 14'sd4096) && (turn_rate_o >= -14'sd4096), "obstacle turn rate out of range")

  // The minimum is below some threshold, so it cannot be the maximum code.
  `LFSAS_ASSERT_SAME(a_obst_near, result_valid_o && obstacle_seen_o, nearest_range_o != '1, "obstacle reported at maximum range")

endmodule

bind lidar_front_sector_avoid_steer lfsas_checker u_lfsas_checker (.*);

>>> tb/lidar_front_sector_avoid_steer_test.sv
// ----------------------------------------------------------------------------
// lidar_front_sector_avoid_steer_test
// Streams lidar scans into the front sector steering block and checks every
// steering result against a cycle-free predictor of the sector minimum, the
// left and right sums and the turn rate. The registers are set over APB
// between phases. Short directed scans come first, then random scans under
// changing source and sink idling.
// ----------------------------------------------------------------------------
module lidar_front_sector_avoid_steer_test
  import lfsas_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic                     obstacle;
    logic signed [TURN_W-1:0] rate;
    logic [RANGE_W-1:0]       nearest;
  } steer_result_t;

  logic                     clk_i;
  logic                     rst_ni          = 1'b0;
  logic [RANGE_W-1:0]       range_sample_i  = '0;
  logic                     range_valid_i   = 1'b0;
  logic                     range_stall_o;
  logic                     obstacle_seen_o;
  logic signed [TURN_W-1:0] turn_rate_o;
  logic [RANGE_W-1:0]       nearest_range_o;
  logic                     result_valid_o;
  logic                     result_stall_i  = 1'b0;
  logic                     psel            = 1'b0;
  logic                     penable         = 1'b0;
  logic                     pwrite          = 1'b0;
  logic [APB_ADDR_W-1:0]    paddr           = '0;
  logic [APB_DATA_W-1:0]    pwdata          = '0;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  // Predictor copy of the registers and of the scan state.
  logic [LEN_REG_W-1:0] cfg_len   = SCAN_LENGTH_RST;
  logic [HW_W-1:0]      cfg_hw    = HALF_WIDTH_RST;
  logic [THR_W-1:0]     cfg_thr   = THRESHOLD_RST;
  int unsigned          scan_pos  = 0;
  logic [RANGE_W-1:0]   run_min   = '1;
  logic [SUM_W-1:0]     left_sum  = '0;
  logic [SUM_W-1:0]     right_sum = '0;

  steer_result_t pending_steer[$];
  int            mismatch_count = 0;
  int            src_idle_pct   = 0;
  int            rcv_stall_pct  = 0;

  lidar_front_sector_avoid_steer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .range_sample_i (range_sample_i),
    .range_valid_i  (range_valid_i),
    .range_stall_o  (range_stall_o),
    .obstacle_seen_o(obstacle_seen_o),
    .turn_rate_o    (turn_rate_o),
    .nearest_range_o(nearest_range_o),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("lidar_front_sector_avoid_steer test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    result_stall_i <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // Advances the scan by one sample; queues a steering result at scan end.
  function automatic void predict_scan_step(input logic [RANGE_W-1:0] x);
    int unsigned       len;
    int unsigned       center;
    int unsigned       hw;
    int unsigned       idx;
    longint unsigned   m;
    longint unsigned   t;
    longint unsigned   mag;
    steer_result_t     r;
    len = cfg_len;
    if (len == 0) len = 1;
    if (len > MAX_SAMPLES_DEF) len = MAX_SAMPLES_DEF;
    center = len / 2;
    hw = cfg_hw;
    if (hw > (len - 1) / 2) hw = (len - 1) / 2;
    idx = scan_pos;
    if (idx + hw >= center && idx <= center + hw) begin
      if (x < run_min) run_min = x;
      if (idx > center) left_sum += x;
      else if (idx < center) right_sum += x;
    end
    if (idx + 1 < len) begin
      scan_pos = idx + 1;
      return;
    end
    m = run_min;
    t = cfg_thr;
    r = '0;
    if (m < t) begin
      mag = (4096 * (10 * t - 7 * m) + 5 * t) / (10 * t);
      r.obstacle = 1'b1;
      // Equal sums steer right.
      r.rate = (left_sum > right_sum) ? TURN_W'(mag) : TURN_W'(-mag);
    end
    r.nearest = run_min;
    pending_steer.push_back(r);
    scan_pos  = 0;
    run_min   = '1;
    left_sum  = '0;
    right_sum = '0;
  endfunction

  task automatic check_steer_result();
    steer_result_t want;
    if (pending_steer.size() == 0) begin
      report_mismatch($sformatf("result with none expected: obstacle %0d rate %0d near %0d",
                                obstacle_seen_o, turn_rate_o, nearest_range_o));
      return;
    end
    want = pending_steer.pop_front();
    if (obstacle_seen_o !== want.obstacle)
      report_mismatch($sformatf("obstacle_seen expected %0d, actual %0d",
                                want.obstacle, obstacle_seen_o));
    if (turn_rate_o !== want.rate)
      report_mismatch($sformatf("turn_rate expected %0d, actual %0d", want.rate, turn_rate_o));
    if (nearest_range_o !== want.nearest)
      report_mismatch($sformatf("nearest_range expected %0d, actual %0d",
                                want.nearest, nearest_range_o));
  endtask

  // Results are taken at the falling edge, where stall and valid are settled.
  always @(negedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i) check_steer_result();
  end

  // Ends with the bus idle, so a following access starts on a later edge.
  task automatic apb_access(input logic wr, input logic [1:0] idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    logic [APB_DATA_W-1:0] want;
    apb_access(1'b1, idx, value, rd);
    want = '0;
    case (idx)
      REG_SCAN_LENGTH: begin
        cfg_len = value[LEN_REG_W-1:0];
        want    = APB_DATA_W'(cfg_len);
      end
      REG_HALF_WIDTH: begin
        cfg_hw = value[HW_W-1:0];
        want   = APB_DATA_W'(cfg_hw);
      end
      REG_THRESHOLD: begin
        cfg_thr = value[THR_W-1:0];
        want    = APB_DATA_W'(cfg_thr);
      end
      default: ;
    endcase
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want)
      report_mismatch($sformatf("register %0d read expected %0d, actual %0d", idx, want, rd));
  endtask

  task automatic set_scan(input logic [APB_DATA_W-1:0] len, input logic [APB_DATA_W-1:0] hw,
                          input logic [APB_DATA_W-1:0] thr);
    write_reg(REG_SCAN_LENGTH, len);
    write_reg(REG_HALF_WIDTH, hw);
    write_reg(REG_THRESHOLD, thr);
  endtask

  // Starts and ends right after a rising edge; valid stays high for a
  // following item unless the source idles first.
  task automatic send_range(input logic [RANGE_W-1:0] x);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      range_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    range_valid_i  <= 1'b1;
    range_sample_i <= x;
    @(negedge clk_i);
    while (range_stall_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    predict_scan_step(x);
    @(posedge clk_i);
  endtask

  // Lets the block go idle so the registers can be written safely.
  task automatic wait_for_results();
    range_valid_i <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [RANGE_W-1:0] pick_range();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return '0;
      1:       return '1;
      2, 3, 4: return (cfg_thr == 0) ? RANGE_W'($urandom)
                                     : RANGE_W'($urandom_range(0, cfg_thr - 1));
      5:       return RANGE_W'(cfg_thr + $urandom_range(0, 4) - 2);
      default: return RANGE_W'($urandom);
    endcase
  endfunction

  task automatic test_register_defaults();
    logic [APB_DATA_W-1:0] rd;
    apb_access(1'b0, REG_SCAN_LENGTH, '0, rd);
    if (rd !== APB_DATA_W'(SCAN_LENGTH_RST))
      report_mismatch($sformatf("scan_length reset expected %0d, actual %0d",
                                SCAN_LENGTH_RST, rd));
    apb_access(1'b0, REG_HALF_WIDTH, '0, rd);
    if (rd !== APB_DATA_W'(HALF_WIDTH_RST))
      report_mismatch($sformatf("half_width reset expected %0d, actual %0d",
                                HALF_WIDTH_RST, rd));
    apb_access(1'b0, REG_THRESHOLD, '0, rd);
    if (rd !== APB_DATA_W'(THRESHOLD_RST))
      report_mismatch($sformatf("threshold reset expected %0d, actual %0d",
                                THRESHOLD_RST, rd));
  endtask

  // A zero scan length acts as one sample, so every item ends a scan.
  task automatic test_single_sample_scans();
    set_scan(0, 0, 65535);
    send_range(16'd0);
    send_range(16'hFFFF);
    send_range(16'hFFFE);
    send_range(16'd1);
    wait_for_results();
    // With a zero threshold nothing is ever near enough.
    write_reg(REG_THRESHOLD, 0);
    send_range(16'd0);
    send_range(16'hFFFF);
    wait_for_results();
  endtask

  task automatic test_sector_clamp_and_sign();
    // Half-width far above the scan is clamped to one sample each side.
    set_scan(3, 511, 65535);
    send_range(16'd10);
    send_range(16'd500);
    send_range(16'd20);
    send_range(16'd20);
    send_range(16'd500);
    send_range(16'd10);
    send_range(16'd7);
    send_range(16'd9);
    send_range(16'd7);
    wait_for_results();
  endtask

  // Shortening the scan while the counter is past the new end closes the scan
  // on the very next item.
  task automatic test_shorten_mid_scan();
    set_scan(8, 2, 300);
    send_range(16'd400);
    send_range(16'd250);
    send_range(16'd290);
    send_range(16'd500);
    send_range(16'd310);
    wait_for_results();
    write_reg(REG_SCAN_LENGTH, 3);
    send_range(16'd100);
    wait_for_results();
  endtask

  task automatic test_random_scans();
    int n_items;
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        src_idle_pct  = 31;
        rcv_stall_pct = 49;
      end else if (p < 8) begin
        src_idle_pct  = 49;
        rcv_stall_pct = 31;
      end else begin
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
      end
      n_items = 90;
      case (p)
        0:  set_scan(1, 0, 1);
        1:  set_scan($urandom_range(2, 48), 511, 65535);
        6: begin
          // Oversized length saturates to the longest scan.
          set_scan(2047, 511, $urandom_range(1, 65535));
          n_items = 1100;
        end
        11: set_scan(48, $urandom_range(0, 23), 65535);
        default: set_scan($urandom_range(1, 48),
                          $urandom_range(0, 1) ? $urandom_range(0, 511)
                                               : $urandom_range(0, 24),
                          $urandom_range(0, 1) ? $urandom_range(1, 65535)
                                               : $urandom_range(100, 5000));
      endcase
      repeat (n_items) send_range(pick_range());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    src_idle_pct  = 31;
    rcv_stall_pct = 49;
    test_single_sample_scans();
    test_sector_clamp_and_sign();
    test_shorten_mid_scan();
    test_random_scans();
    wait_for_results();
    if (mismatch_count == 0 && pending_steer.size() == 0) begin
      $display("lidar_front_sector_avoid_steer test passed");
    end else begin
      $display("lidar_front_sector_avoid_steer test failed");
    end
    $finish;
  end

endmodule

>>> lidar_front_sector_avoid_steer.f
+incdir+design
design/lfsas_pkg.sv
design/lfsas_cfg.sv
design/lfsas_front.sv
design/lfsas_queue.sv
design/lfsas_back.sv
design/lidar_front_sector_avoid_steer.sv
design/lfsas_checker.sv
tb/lidar_front_sector_avoid_steer_test.sv
